// ----- rtl/chol_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chol_pkg: shared types for the small-matrix Cholesky factor block.
// Holds the request and result payload types, the controller states and the
// command/status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package chol_pkg;

    typedef struct packed {
        logic signed [15:0] matrix_element;
        logic               final_element;
    } chol_in_t;

    typedef struct packed {
        logic signed [15:0] factor_value;
        logic [1:0]         row_index;
        logic [1:0]         column_index;
        logic               not_positive_definite;
        logic               last_entry;
    } chol_out_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_MAC,
        ST_PREP,
        ST_ITER,
        ST_STORE,
        ST_EMIT
    } chol_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_acc;  // clear the sum accumulator
        logic mac;        // add L[i][k]*L[j][k] to the accumulator
        logic prep;       // form the difference and set up the iteration
        logic iter;       // one root or quotient step
        logic store;      // saturate and write L[i][j]
    } chol_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic iter_done;
    } chol_stat_t;

endpackage

// ----- rtl/chol_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chol_datapath: matrix stores and arithmetic of the Cholesky factor.
// Holds A and L, one multiply-accumulate, and a shared unit that runs a
// restoring square root (two bits per step) or a restoring division
// (one bit per step).
// ----------------------------------------------------------------------------
module chol_datapath #(
    parameter int MAX_SIZE  = 3,
    parameter int FRAC_BITS = 14
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load_we,
    input  logic [$clog2(MAX_SIZE*MAX_SIZE+1)-1:0] load_addr,
    input  logic signed [15:0]  load_data,
    input  logic [$clog2(MAX_SIZE+1)-1:0] size_n,
    input  logic [$clog2(MAX_SIZE+1)-1:0] idx_i,
    input  logic [$clog2(MAX_SIZE+1)-1:0] idx_j,
    input  logic [$clog2(MAX_SIZE+1)-1:0] idx_k,
    input  chol_pkg::chol_cmd_t cmd,
    output chol_pkg::chol_stat_t stat,
    output logic signed [15:0]  result_value,
    output logic                pivot_fail
);
    import chol_pkg::*;

    localparam int CELLS = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(CELLS + 1);
    // Difference width: the larger of the scaled entry and the sum of up to
    // MAX_SIZE-1 products of 16-bit values, plus sign and guard. It is kept
    // even so that the square root works on whole bit pairs.
    localparam int DW_RAW = ((15 + FRAC_BITS > 30 + $clog2(MAX_SIZE)) ?
                             15 + FRAC_BITS : 30 + $clog2(MAX_SIZE)) + 2;
    localparam int DW    = DW_RAW + (DW_RAW % 2);
    localparam int QW    = DW;
    localparam int SSTEPS = DW / 2;
    localparam int CW    = $clog2(QW + 1);

    logic signed [15:0] a_mem [CELLS];
    logic signed [15:0] l_mem [CELLS];

    logic signed [DW-1:0] acc_reg;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW+1:0]        root_reg, root_next;   // also quotient
    logic [DW-1:0]        num_reg;               // magnitude being worked
    logic [15:0]          div_reg;
    logic                 neg_reg, zero_reg, is_diag_reg, fail_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [15:0]   val_reg;

    logic [AW-1:0] addr_ik, addr_jk, addr_ij, addr_jj, addr_a;
    logic signed [31:0] prod;
    logic signed [DW-1:0] diff;
    logic signed [15:0] piv;

    always_comb begin
        addr_ik = AW'(32'(idx_i) * MAX_SIZE + 32'(idx_k));
        addr_jk = AW'(32'(idx_j) * MAX_SIZE + 32'(idx_k));
        addr_ij = AW'(32'(idx_i) * MAX_SIZE + 32'(idx_j));
        addr_jj = AW'(32'(idx_j) * MAX_SIZE + 32'(idx_j));
        addr_a  = AW'(32'(idx_i) * 32'(size_n) + 32'(idx_j));
        prod    = l_mem[addr_ik] * l_mem[addr_jk];
        diff    = (DW'(a_mem[addr_a]) <<< FRAC_BITS) - acc_reg;
        piv     = l_mem[addr_jj];
    end

    // Input store.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            a_mem[load_addr] <= load_data;
        end
    end

    // Iteration step: root uses two bits of the remainder pair per step,
    // division shifts one numerator bit in per step.
    logic [DW+1:0] trial;
    logic [DW+1:0] rem_wide;
    always_comb begin
        rem_next  = rem_reg;
        root_next = root_reg;
        trial     = '0;
        rem_wide  = '0;
        if (is_diag_reg) begin
            rem_wide = {rem_reg[DW-1:0], num_reg[DW-1 -: 2]};
            trial    = {root_reg[DW-1:0], 2'b01};
            if (rem_wide >= trial) begin
                rem_next  = DW'(rem_wide - trial);
                root_next = {root_reg[DW:0], 1'b1};
            end else begin
                rem_next  = DW'(rem_wide);
                root_next = {root_reg[DW:0], 1'b0};
            end
        end else begin
            rem_wide = {1'b0, rem_reg, num_reg[DW-1]};
            trial    = (DW+2)'(div_reg);
            if (rem_wide >= trial) begin
                rem_next  = DW'(rem_wide - trial);
                root_next = {root_reg[DW:0], 1'b1};
            end else begin
                rem_next  = DW'(rem_wide);
                root_next = {root_reg[DW:0], 1'b0};
            end
        end
    end

    // Saturation of the finished magnitude with its sign.
    logic signed [DW+2:0] sval;
    always_comb begin
        sval = neg_reg ? -$signed({1'b0, root_reg}) : $signed({1'b0, root_reg});
        if (zero_reg) begin
            val_reg = '0;
        end else if (sval > 32767) begin
            val_reg = 16'sh7fff;
        end else if (sval < -32768) begin
            val_reg = -16'sh8000;
        end else begin
            val_reg = 16'(sval);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_acc) begin
            acc_reg <= '0;
        end else if (cmd.mac) begin
            acc_reg <= acc_reg + DW'(prod);
        end
        if (cmd.prep) begin
            is_diag_reg <= (idx_i == idx_j);
            rem_reg     <= '0;
            root_reg    <= '0;
            div_reg     <= piv;
            if (idx_i == idx_j) begin
                zero_reg <= (diff <= 0);
                neg_reg  <= 1'b0;
                num_reg  <= diff;
                cnt_reg  <= CW'(SSTEPS);
            end else begin
                zero_reg <= (piv <= 0);
                neg_reg  <= diff[DW-1];
                num_reg  <= diff[DW-1] ? -diff : diff;
                cnt_reg  <= CW'(QW);
            end
        end else if (cmd.iter) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            num_reg  <= is_diag_reg ? (num_reg << 2) : (num_reg << 1);
            cnt_reg  <= cnt_reg - 1'b1;
        end
        if (cmd.store) begin
            l_mem[addr_ij] <= val_reg;
        end
    end

    // Error flag of the current run.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_acc && idx_i == '0 && idx_j == '0) begin
            fail_reg <= 1'b0;
        end else if (cmd.store && is_diag_reg && zero_reg) begin
            fail_reg <= 1'b1;
        end
    end

    assign stat.iter_done = (cnt_reg == '0);
    assign result_value   = val_reg;
    assign pivot_fail     = fail_reg || (is_diag_reg && zero_reg);
endmodule

// ----- rtl/chol_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chol_ctrl: sequencer of the Cholesky factor.
// Counts loaded entries, walks the (i, j, k) loops and drives the datapath
// and the result register.
// ----------------------------------------------------------------------------
module chol_ctrl #(
    parameter int MAX_SIZE = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                final_in,
    input  logic [1:0]          matrix_size,
    output logic                load_we,
    output logic [$clog2(MAX_SIZE*MAX_SIZE+1)-1:0] load_addr,
    output logic [$clog2(MAX_SIZE+1)-1:0] size_n,
    output logic [$clog2(MAX_SIZE+1)-1:0] idx_i,
    output logic [$clog2(MAX_SIZE+1)-1:0] idx_j,
    output logic [$clog2(MAX_SIZE+1)-1:0] idx_k,
    output chol_pkg::chol_cmd_t cmd,
    input  chol_pkg::chol_stat_t stat,
    output logic                emit,
    output logic                emit_last,
    input  logic                out_free
);
    import chol_pkg::*;

    localparam int AW = $clog2(MAX_SIZE * MAX_SIZE + 1);
    localparam int IW = $clog2(MAX_SIZE + 1);

    chol_state_t state_reg, state_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [IW-1:0] n_reg, n_next, i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IW-1:0] n_cur;
    logic accept;

    // Active size with zero and overflow clamped.
    always_comb begin
        n_cur = (matrix_size == 2'd0) ? IW'(1) : IW'(matrix_size);
        if (32'(n_cur) > MAX_SIZE) begin
            n_cur = IW'(MAX_SIZE);
        end
    end

    assign s_ready   = (state_reg == ST_LOAD);
    assign accept    = s_valid && s_ready;
    assign load_we   = accept && (32'(pos_reg) < 32'(n_cur) * 32'(n_cur));
    assign load_addr = pos_reg;
    assign size_n    = n_reg;
    assign idx_i     = i_reg;
    assign idx_j     = j_reg;
    assign idx_k     = k_reg;
    assign emit_last = (i_reg == n_reg - 1'b1) && (j_reg == i_reg);

    // Next state and counters.
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (load_we) begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (final_in) begin
                        pos_next   = '0;
                        n_next     = n_cur;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                k_next     = '0;
                state_next = (j_reg == '0) ? ST_PREP : ST_MAC;
            end
            ST_MAC: begin
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 == j_reg) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_ITER;
            ST_ITER: begin
                if (stat.iter_done) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    if (emit_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_INIT;
                        if (j_reg == i_reg) begin
                            i_next = i_reg + 1'b1;
                            j_next = '0;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Commands.
    always_comb begin
        cmd       = '0;
        emit      = 1'b0;
        unique case (state_reg)
            ST_INIT:  cmd.clear_acc = 1'b1;
            ST_MAC:   cmd.mac       = 1'b1;
            ST_PREP:  cmd.prep      = 1'b1;
            ST_ITER:  cmd.iter      = !stat.iter_done;
            ST_STORE: cmd.store     = 1'b1;
            ST_EMIT:  emit          = out_free;
            default:  cmd           = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            pos_reg   <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end
endmodule

// ----- rtl/cholesky_factor_small_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cholesky_factor_small_matrix: lower Cholesky factor of a small matrix.
// Loads an n-by-n matrix one entry per request, then computes each factor
// entry in turn: a multiply-accumulate over the j earlier columns, then a
// square root (17 steps of two bits) or a division (34 steps of one bit) in
// the shared iterative unit with the default parameters, plus set-up, store
// and result hand-off states. The iterative unit sets the rate. Results leave
// through a register, so the next load can begin while the last result waits.
// ----------------------------------------------------------------------------
module cholesky_factor_small_matrix #(
    parameter int MAX_SIZE  = 3,
    parameter int FRAC_BITS = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  chol_pkg::chol_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output chol_pkg::chol_out_t  m_data
);
    import chol_pkg::*;

    localparam int AW = $clog2(MAX_SIZE * MAX_SIZE + 1);
    localparam int IW = $clog2(MAX_SIZE + 1);

    logic [1:0] size_reg;
    logic load_we, emit, emit_last, out_free, pivot_fail;
    logic [AW-1:0] load_addr;
    logic [IW-1:0] size_n, idx_i, idx_j, idx_k;
    logic signed [15:0] result_value;
    chol_cmd_t  cmd;
    chol_stat_t stat;
    chol_out_t  out_reg;
    logic       out_valid_reg;

    // Size register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= 2'd3;
        end else if (cfg_valid) begin
            size_reg <= cfg_data;
        end
    end

    chol_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready,
        .final_in(s_data.final_element), .matrix_size(size_reg),
        .load_we, .load_addr, .size_n, .idx_i, .idx_j, .idx_k,
        .cmd, .stat, .emit, .emit_last, .out_free
    );

    chol_datapath #(.MAX_SIZE(MAX_SIZE), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk, .aresetn, .load_we, .load_addr,
        .load_data(s_data.matrix_element), .size_n,
        .idx_i, .idx_j, .idx_k, .cmd, .stat, .result_value, .pivot_fail
    );

    // Result register.
    assign out_free = !out_valid_reg || m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg.factor_value          <= result_value;
            out_reg.row_index             <= 2'(idx_i);
            out_reg.column_index          <= 2'(idx_j);
            out_reg.not_positive_definite <= pivot_fail;
            out_reg.last_entry            <= emit_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the small-matrix Cholesky factor block.
// Matrices are streamed in one entry per request under random burst gaps.
// The result channel stalls on its own pattern. A fixed-point factor
// predictor computes the expected lower-triangle entries, and every result
// is compared field by field against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module tb_top;
    import chol_pkg::*;

    localparam int DIM       = 3;
    localparam int FRAC      = 14;
    localparam int CYCLE_CAP = 1000000;

    // Fixed-point factor predictor with its queue of pending factor entries.
    class cholesky_scoreboard;
        int             order_cfg;
        int             fill_pos;
        logic signed [15:0] a_cells [DIM*DIM];
        logic signed [15:0] l_cells [DIM*DIM];
        chol_out_t      expected_factors[$];
        int             errors;

        function new();
            order_cfg = 3;
            fill_pos  = 0;
            errors    = 0;
        endfunction

        function int order();
            if (order_cfg == 0) return 1;
            if (order_cfg > DIM) return DIM;
            return order_cfg;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, b_mask;
            res = 0;
            b_mask = 64'd1 << 62;
            while (b_mask > v) b_mask >>= 2;
            while (b_mask != 0) begin
                if (v >= res + b_mask) begin
                    v -= res + b_mask;
                    res = (res >> 1) + b_mask;
                end else begin
                    res >>= 1;
                end
                b_mask >>= 2;
            end
            return res;
        endfunction

        function logic signed [15:0] clip16(longint v);
            if (v > 32767) return 16'sd32767;
            if (v < -32768) return -16'sd32768;
            return v[15:0];
        endfunction

        // Loads one entry; a final mark factors the matrix and queues its entries.
        function void note_request(chol_in_t req);
            int n;
            longint acc, diff, val;
            logic pivot_bad;
            chol_out_t res;
            n = order();
            if (fill_pos < n * n) begin
                a_cells[fill_pos] = req.matrix_element;
                fill_pos++;
            end
            if (!req.final_element) return;
            fill_pos  = 0;
            pivot_bad = 1'b0;
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j <= i; j++) begin
                    acc = 0;
                    for (int k = 0; k < j; k++)
                        acc += longint'(l_cells[i*DIM+k]) * longint'(l_cells[j*DIM+k]);
                    diff = longint'(a_cells[i*n+j]) * (longint'(1) << FRAC) - acc;
                    if (i == j) begin
                        if (diff <= 0) begin
                            pivot_bad = 1'b1;
                            val = 0;
                        end else begin
                            val = longint'(int_sqrt(diff));
                        end
                    end else begin
                        // A failed pivot forces the column below it to zero.
                        if (l_cells[j*DIM+j] > 0)
                            val = diff / longint'(l_cells[j*DIM+j]);
                        else
                            val = 0;
                    end
                    l_cells[i*DIM+j] = clip16(val);
                    res.factor_value          = l_cells[i*DIM+j];
                    res.row_index             = 2'(i);
                    res.column_index          = 2'(j);
                    res.not_positive_definite = pivot_bad;
                    res.last_entry            = (i == n - 1) && (j == i);
                    expected_factors.push_back(res);
                end
            end
        endfunction

        function void check_factor(chol_out_t got);
            chol_out_t want;
            if (expected_factors.size() == 0) begin
                $display("%0t: unexpected result value=%0d row=%0d col=%0d npd=%0b last=%0b",
                         $time, got.factor_value, got.row_index, got.column_index,
                         got.not_positive_definite, got.last_entry);
                errors++;
                return;
            end
            want = expected_factors.pop_front();
            if (got.factor_value !== want.factor_value ||
                got.row_index !== want.row_index ||
                got.column_index !== want.column_index ||
                got.not_positive_definite !== want.not_positive_definite ||
                got.last_entry !== want.last_entry) begin
                $display("%0t: mismatch expected value=%0d row=%0d col=%0d npd=%0b last=%0b",
                         $time, want.factor_value, want.row_index, want.column_index,
                         want.not_positive_definite, want.last_entry);
                $display("%0t:          actual   value=%0d row=%0d col=%0d npd=%0b last=%0b",
                         $time, got.factor_value, got.row_index, got.column_index,
                         got.not_positive_definite, got.last_entry);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    chol_in_t   s_data;
    logic       m_valid;
    logic       m_ready;
    chol_out_t  m_data;

    cholesky_scoreboard sb;
    int unsigned cycle_count;
    int          burst_left;
    int          sent_items;

    cholesky_factor_small_matrix #(.MAX_SIZE(DIM), .FRAC_BITS(FRAC)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver stall pattern: free-running, random, and long-stall stretches.
    int unsigned stall_mode;
    int unsigned stall_timer;
    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(20, 200);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= $urandom_range(0, 1);
            end
            default: begin
                m_ready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_factor(m_data);
    end

    // Stops sending and waits until every expected result has come.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.expected_factors.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_size(input logic [1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.order_cfg = value;
        cfg_valid <= 1'b0;
    endtask

    // Sends one request, with random gaps between bursts.
    task automatic send_request(input logic signed [15:0] elem, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= '{matrix_element: elem, final_element: fin};
        do @(posedge aclk); while (!s_ready);
        sb.note_request('{matrix_element: elem, final_element: fin});
        sent_items++;
    endtask

    // Full n-by-n matrix with a fixed diagonal and off-diagonal value.
    task automatic send_matrix(input logic signed [15:0] diag, input logic signed [15:0] off);
        int n;
        n = sb.order();
        for (int p = 0; p < n * n; p++)
            send_request((p / n == p % n) ? diag : off, p == n * n - 1);
    endtask

    // Random matrix: mostly correlation-like, sometimes full-range entries.
    task automatic send_random_matrix();
        int n;
        logic signed [15:0] e;
        bit wild;
        n = sb.order();
        wild = ($urandom_range(0, 4) == 0);
        for (int p = 0; p < n * n; p++) begin
            if (wild)
                e = 16'($urandom);
            else if (p / n == p % n)
                e = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 32767)) : 16'sd16384;
            else
                e = 16'($signed($urandom_range(0, 32768)) - 16384);
            send_request(e, p == n * n - 1);
        end
    endtask

    // Broken sequence: random length, final mark on the last entry only.
    task automatic send_noise();
        int cnt;
        cnt = $urandom_range(1, 12);
        for (int p = 0; p < cnt; p++)
            send_request(16'($urandom), p == cnt - 1);
    endtask

    initial begin
        sb          = new();
        cycle_count = 0;
        stall_mode  = 0;
        stall_timer = 0;
        burst_left  = 0;
        sent_items  = 0;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 2'd3;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: a full 3x3 first, so every cell has been written.
        write_size(2'd3);
        send_matrix(16'sd16384, 16'sd0);
        send_matrix(16'sd32767, -16'sd32768);
        // Non-positive pivots.
        send_matrix(-16'sd32768, 16'sd8192);
        send_matrix(16'sd0, 16'sd0);
        // Early final mark after two entries.
        send_request(16'sd4096, 1'b0);
        send_request(-16'sd1, 1'b1);
        // Size zero acts as one; extra entries are dropped.
        write_size(2'd0);
        send_request(16'sd100, 1'b0);
        send_request(16'sd32767, 1'b0);
        send_request(-16'sd32768, 1'b1);
        write_size(2'd2);
        send_matrix(16'sd16384, -16'sd12000);
        write_size(2'd1);
        send_request(16'sd32767, 1'b1);

        // Random part.
        while (sent_items < 200) begin
            if ($urandom_range(0, 5) == 0)
                write_size(2'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) == 0) begin
                s_valid <= 1'b0;
                burst_left = 0;
                wait_idle();
            end
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_random_matrix();
        end
        s_valid <= 1'b0;

        wait_idle();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_factors.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
